// ===== sv/tmf_pkg.sv =====
// Shared constants for the address translator with TLB and FIFO frame replacement.
// No dependencies; every other file imports this package.
package tmf_pkg;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 8;
    localparam int FRAME_BITS_DEF  = 7;
    localparam int TLB_DEPTH_DEF   = 16;
endpackage

// ===== sv/tmf_front.sv =====
// Front end: two-beat input queue that splits each address into page and offset.
// Depends on tmf_pkg.
module tmf_front
    import tmf_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [PAGE_BITS+OFFSET_BITS-1:0] logical_address,
    output logic                              q_empty,
    input  logic                              q_pop,
    output logic [PAGE_BITS-1:0]              q_page,
    output logic [OFFSET_BITS-1:0]            q_offset
);
    localparam int AW = PAGE_BITS + OFFSET_BITS;

    logic [AW-1:0] slot_reg [2];
    logic [1:0]    count_reg, count_next;
    logic          wr_reg, rd_reg;
    logic          do_push, do_pop;

    assign full     = count_reg == 2'd2;
    assign q_empty  = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = q_pop && !q_empty;
    assign q_page   = slot_reg[rd_reg][AW-1:OFFSET_BITS];
    assign q_offset = slot_reg[rd_reg][OFFSET_BITS-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= logical_address;
        end
    end
endmodule

// ===== sv/tmf_result_queue.sv =====
// Two-beat result queue between the translation engine and the result ports.
// Depends on tmf_pkg.
module tmf_result_queue
    import tmf_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              r_push,
    output logic                              r_full,
    input  logic [FRAME_BITS+OFFSET_BITS-1:0] r_pa,
    input  logic                              r_hit,
    input  logic                              r_fault,
    input  logic                              r_ev_valid,
    input  logic [PAGE_BITS-1:0]              r_ev_page,
    output logic                              empty,
    input  logic                              pop,
    output logic [FRAME_BITS+OFFSET_BITS-1:0] physical_address,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              evicted_valid,
    output logic [PAGE_BITS-1:0]              evicted_page
);
    localparam int PW = FRAME_BITS + OFFSET_BITS;
    localparam int DW = PW + 3 + PAGE_BITS;

    logic [DW-1:0] slot_reg [2];
    logic [DW-1:0] head;
    logic [1:0]    count_reg, count_next;
    logic          wr_reg, rd_reg;
    logic          do_push, do_pop;

    assign r_full  = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_push = r_push && !r_full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_reg];

    assign physical_address = head[DW-1:DW-PW];
    assign tlb_hit          = head[PAGE_BITS+2];
    assign page_fault       = head[PAGE_BITS+1];
    assign evicted_valid    = head[PAGE_BITS];
    assign evicted_page     = head[PAGE_BITS-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= {r_pa, r_hit, r_fault, r_ev_valid, r_ev_page};
        end
    end
endmodule

// ===== sv/tmf_back.sv =====
// Translation engine: TLB lookup, page table and frame owner memories, FIFO replacement.
// Depends on tmf_pkg; fed by tmf_front, drains into tmf_result_queue.
module tmf_back
    import tmf_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TLB_DEPTH   = TLB_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              q_pop,
    input  logic [PAGE_BITS-1:0]              q_page,
    input  logic [OFFSET_BITS-1:0]            q_offset,
    output logic                              r_push,
    input  logic                              r_full,
    output logic [FRAME_BITS+OFFSET_BITS-1:0] r_pa,
    output logic                              r_hit,
    output logic                              r_fault,
    output logic                              r_ev_valid,
    output logic [PAGE_BITS-1:0]              r_ev_page
);
    localparam int IW        = $clog2(TLB_DEPTH);
    localparam int NUM_PAGES = 1 << PAGE_BITS;
    localparam int NUM_FRAMES = 1 << FRAME_BITS;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_PT   = 2'd2;
    localparam logic [IW-1:0] TPTR_LAST = IW'(TLB_DEPTH - 1);

    logic [1:0]             state_reg, state_next;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [PAGE_BITS-1:0]   tag_reg [TLB_DEPTH];
    logic [FRAME_BITS-1:0]  frm_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0]   vld_reg;
    logic [IW-1:0]          tptr_reg;
    logic [FRAME_BITS-1:0]  fptr_reg;
    logic                   wrap_reg;
    logic [NUM_PAGES-1:0]   pvalid_reg, pvalid_next;
    logic [FRAME_BITS-1:0]  pmap_mem [NUM_PAGES];
    logic [PAGE_BITS-1:0]   owner_mem [NUM_FRAMES];
    logic [FRAME_BITS-1:0]  pmap_rd_reg;
    logic [PAGE_BITS-1:0]   owner_rd_reg;

    logic                   hit_any, rt_any;
    logic [IW-1:0]          hit_idx, rt_idx;
    logic                   mapped, fault, evict, retarget;
    logic [FRAME_BITS-1:0]  frame_sel;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        rt_any  = 1'b0;
        rt_idx  = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (vld_reg[i] && tag_reg[i] == page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IW'(i);
            end
            if (vld_reg[i] && frm_reg[i] == fptr_reg)
            begin
                rt_any = 1'b1;
                rt_idx = IW'(i);
            end
        end
    end

    assign mapped    = pvalid_reg[page_reg];
    assign fault     = !mapped;
    assign evict     = fault && wrap_reg;
    assign retarget  = evict && rt_any;
    assign frame_sel = mapped ? pmap_rd_reg : fptr_reg;

    assign q_pop = (state_reg == S_IDLE) && !q_empty && !r_full;

    always_comb
    begin
        pvalid_next = pvalid_reg;
        if (state_reg == S_PT && fault)
        begin
            if (evict)
            begin
                pvalid_next[owner_rd_reg] = 1'b0;
            end
            pvalid_next[page_reg] = 1'b1;
        end
    end

    always_comb
    begin
        r_push     = 1'b0;
        r_pa       = {frame_sel, offset_reg};
        r_hit      = 1'b0;
        r_fault    = 1'b0;
        r_ev_valid = 1'b0;
        r_ev_page  = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (hit_any)
                begin
                    r_push     = 1'b1;
                    r_hit      = 1'b1;
                    r_pa       = {frm_reg[hit_idx], offset_reg};
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PT;
                end
            end
            S_PT:
            begin
                r_push     = 1'b1;
                r_fault    = fault;
                r_ev_valid = evict;
                r_ev_page  = evict ? owner_rd_reg : '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vld_reg    <= '0;
            tptr_reg   <= '0;
            fptr_reg   <= '0;
            wrap_reg   <= 1'b0;
            pvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pvalid_reg <= pvalid_next;
            if (state_reg == S_PT)
            begin
                if (!retarget)
                begin
                    vld_reg[tptr_reg] <= 1'b1;
                    tptr_reg <= (tptr_reg == TPTR_LAST) ? '0 : tptr_reg + 1'b1;
                end
                if (fault)
                begin
                    fptr_reg <= fptr_reg + 1'b1;
                    if (&fptr_reg)
                    begin
                        wrap_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            page_reg   <= q_page;
            offset_reg <= q_offset;
        end
        if (state_reg == S_PT)
        begin
            if (retarget)
            begin
                tag_reg[rt_idx] <= page_reg;
            end
            else
            begin
                tag_reg[tptr_reg] <= page_reg;
                frm_reg[tptr_reg] <= frame_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK)
        begin
            pmap_rd_reg <= pmap_mem[page_reg];
        end
        if (state_reg == S_PT && fault)
        begin
            pmap_mem[page_reg] <= fptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOOK)
        begin
            owner_rd_reg <= owner_mem[fptr_reg];
        end
        if (state_reg == S_PT && fault)
        begin
            owner_mem[fptr_reg] <= page_reg;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        r_push |-> !r_full)
        else $error("Result beat pushed into a full queue.");
    a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        r_push |-> !(r_hit && r_fault))
        else $error("Result flags both a TLB hit and a page fault.");
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (r_push && r_ev_valid) |-> r_fault)
        else $error("Eviction reported without a page fault.");
    a_fault_maps: assert property (@(posedge clk) disable iff (!rst_n)
        (r_push && r_fault) |=> pvalid_reg[$past(page_reg)])
        else $error("Faulting page was not mapped afterwards.");
    a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
        r_push |=> !r_push)
        else $error("Two result beats pushed for one address.");
endmodule

// ===== sv/tlb_mmu_fifo_page_replacement.sv =====
// Top level of the address translator: TLB, page table and FIFO frame replacement.
// Depends on tmf_pkg, tmf_front, tmf_back and tmf_result_queue.
//
// Logical addresses enter through a queue-style port: a beat is taken when push
// is high and full is low. The upper PAGE_BITS of the address select the page and
// the lower OFFSET_BITS pass through as the offset. Results leave through a second
// queue: while empty is low the oldest result sits on the result ports, and pop
// takes it. Every address gives exactly one result, in order.
// The engine handles one address at a time. A TLB hit pushes the result into the output
// queue from S_LOOK, the state that follows the engine picking up the address; a miss
// goes on to S_PT, which uses the registered reads of the page table and frame owner
// memories. The engine returns to S_IDLE before it takes the next address, so it takes
// no new address until the last one's result has entered the output queue.
// Reset empties both queues, clears every TLB valid bit and every page-table valid
// bit, and restarts both replacement pointers; no clearing pass is needed.
// When the receiver stops popping, the output queue fills, the engine waits, and
// the input queue holds up to two addresses before full rises.
module tlb_mmu_fifo_page_replacement
    import tmf_pkg::*;
#(
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF,
    parameter int TLB_DEPTH   = TLB_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [PAGE_BITS+OFFSET_BITS-1:0] logical_address,
    output logic                              empty,
    input  logic                              pop,
    output logic [FRAME_BITS+OFFSET_BITS-1:0] physical_address,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              evicted_valid,
    output logic [PAGE_BITS-1:0]              evicted_page
);
    logic                              q_empty, q_pop;
    logic [PAGE_BITS-1:0]              q_page;
    logic [OFFSET_BITS-1:0]            q_offset;
    logic                              r_push, r_full;
    logic [FRAME_BITS+OFFSET_BITS-1:0] r_pa;
    logic                              r_hit, r_fault, r_ev_valid;
    logic [PAGE_BITS-1:0]              r_ev_page;

    tmf_front #(
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .logical_address (logical_address),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .q_page          (q_page),
        .q_offset        (q_offset)
    );

    tmf_back #(
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .FRAME_BITS  (FRAME_BITS),
        .TLB_DEPTH   (TLB_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_page     (q_page),
        .q_offset   (q_offset),
        .r_push     (r_push),
        .r_full     (r_full),
        .r_pa       (r_pa),
        .r_hit      (r_hit),
        .r_fault    (r_fault),
        .r_ev_valid (r_ev_valid),
        .r_ev_page  (r_ev_page)
    );

    tmf_result_queue #(
        .PAGE_BITS   (PAGE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .FRAME_BITS  (FRAME_BITS)
    ) u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .r_push           (r_push),
        .r_full           (r_full),
        .r_pa             (r_pa),
        .r_hit            (r_hit),
        .r_fault          (r_fault),
        .r_ev_valid       (r_ev_valid),
        .r_ev_page        (r_ev_page),
        .empty            (empty),
        .pop              (pop),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .evicted_valid    (evicted_valid),
        .evicted_page     (evicted_page)
    );
endmodule

// ===== verif/tb_tlb_mmu_fifo_page_replacement.sv =====
// Self-checking testbench for the address translator with TLB and FIFO frame replacement.
// Depends on tmf_pkg and tlb_mmu_fifo_page_replacement; a translation class predicts each beat.
`timescale 1ns / 1ps

module tb_tlb_mmu_fifo_page_replacement;
    import tmf_pkg::*;

    localparam int PB = PAGE_BITS_DEF;
    localparam int OB = OFFSET_BITS_DEF;
    localparam int FB = FRAME_BITS_DEF;
    localparam int TD = TLB_DEPTH_DEF;
    localparam int NPAGE = 1 << PB;
    localparam int NFRAME = 1 << FB;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [FB+OB-1:0] pa;
        logic             hit;
        logic             fault;
        logic             ev_valid;
        logic [PB-1:0]    ev_page;
    } xlate_t;

    class translation_board;
        logic [PB-1:0] tag [TD];
        logic [FB-1:0] tframe [TD];
        bit            tvalid [TD];
        int            tptr;
        bit            pm_valid [NPAGE];
        logic [FB-1:0] pm_frame [NPAGE];
        bit            own_valid [NFRAME];
        logic [PB-1:0] own_page [NFRAME];
        int            fptr;
        xlate_t        pending [$];
        int            errors;

        function new();
            tptr = 0;
            fptr = 0;
            errors = 0;
            foreach (tvalid[i]) tvalid[i] = 0;
            foreach (pm_valid[i]) pm_valid[i] = 0;
            foreach (own_valid[i]) own_valid[i] = 0;
        endfunction

        function void note_address(logic [PB+OB-1:0] addr);
            logic [PB-1:0] page;
            logic [FB-1:0] frame;
            logic [PB-1:0] old;
            xlate_t r;
            int idx;
            bit retargeted;
            page = addr[PB+OB-1:OB];
            r = '0;
            idx = -1;
            retargeted = 0;
            for (int i = 0; i < TD; i++)
                if (idx < 0 && tvalid[i] && tag[i] == page) idx = i;
            if (idx >= 0)
            begin
                r.hit = 1;
                frame = tframe[idx];
            end
            else
            begin
                if (pm_valid[page])
                    frame = pm_frame[page];
                else
                begin
                    r.fault = 1;
                    frame = fptr[FB-1:0];
                    if (own_valid[frame])
                    begin
                        old = own_page[frame];
                        r.ev_valid = 1;
                        r.ev_page = old;
                        pm_valid[old] = 0;
                        for (int i = 0; i < TD; i++)
                            if (!retargeted && tvalid[i] && tframe[i] == pm_frame[old])
                            begin
                                tag[i] = page;
                                retargeted = 1;
                            end
                    end
                    own_valid[frame] = 1;
                    own_page[frame] = page;
                    fptr = (fptr + 1) % NFRAME;
                    pm_valid[page] = 1;
                    pm_frame[page] = frame;
                end
                if (!retargeted)
                begin
                    tag[tptr] = page;
                    tframe[tptr] = frame;
                    tvalid[tptr] = 1;
                    tptr = (tptr + 1) % TD;
                end
            end
            r.pa = {frame, addr[OB-1:0]};
            pending.push_back(r);
        endfunction

        function void check_result(xlate_t got);
            xlate_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.pa !== exp.pa)
                $display("%0t: physical_address exp %h got %h", $time, exp.pa, got.pa);
            if (got.hit !== exp.hit)
                $display("%0t: tlb_hit exp %b got %b", $time, exp.hit, got.hit);
            if (got.fault !== exp.fault)
                $display("%0t: page_fault exp %b got %b", $time, exp.fault, got.fault);
            if (got.ev_valid !== exp.ev_valid)
                $display("%0t: evicted_valid exp %b got %b", $time, exp.ev_valid, got.ev_valid);
            if (got.ev_page !== exp.ev_page)
                $display("%0t: evicted_page exp %h got %h", $time, exp.ev_page, got.ev_page);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic [PB+OB-1:0] logical_address = '0;
    logic full, empty, tlb_hit, page_fault, evicted_valid;
    logic [FB+OB-1:0] physical_address;
    logic [PB-1:0] evicted_page;

    translation_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;
    int quiet = 0;
    bit done = 0;

    always #5 clk = ~clk;

    tlb_mmu_fifo_page_replacement u_top (.*);

    task automatic send_address(logic [PB+OB-1:0] addr);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        logical_address <= addr;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_address(addr);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [PB+OB-1:0] pick_address(int phase);
        logic [PB-1:0] page;
        case ($urandom_range(3))
            0: page = PB'($urandom);
            1: page = PB'($urandom_range(15));
            default: page = PB'($urandom_range(phase * 40 + 140));
        endcase
        return {page, 8'($urandom)};
    endfunction

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 0;
        end
        else
            pop <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && !empty && pop)
            board.check_result({physical_address, tlb_hit, page_fault,
                                evicted_valid, evicted_page});
        if ((push && !full) || (pop && !empty) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h00FF);
        send_address(16'hFF00);
        send_address(16'h5AA5);
        send_address(16'hA55A);
        for (int i = 0; i < 18; i++)
            send_address({8'(i), 8'($urandom)});
        hold_off = 60;
        for (int i = 0; i < 12; i++)
            send_address({8'($urandom_range(20)), 8'($urandom)});
        drain();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 1) ? 61 : (phase == 3) ? 31 : 0;
            recv_stall = (phase == 2) ? 61 : (phase == 3) ? 31 : 0;
            for (int i = 0; i < 170; i++)
                send_address(pick_address(phase));
            drain();
        end
        done = 1;
        repeat (10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
